[sv/q2k_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2k_pkg: shared types and constants of the 2-bit block dequantizer
// Holds the queue word format, the command codes and the float constants.
// ----------------------------------------------------------------------------
package q2k_pkg;

  // Command codes of an input word.
  typedef enum logic {
    CMD_HEADER = 1'b0,
    CMD_QUANT  = 1'b1
  } cmd_e;

  // Width of the exact aligned difference.
  localparam int MagW = 47;

  // Offset from (msb position + smaller half exponent) to the fp32 exponent.
  localparam logic [7:0] ExpOffset = 8'd102;

  // Canonical quiet NaN of the result.
  localparam logic [31:0] CanonNan = 32'h7FC0_0000;

  // One quant byte with everything it needs from the block state.
  typedef struct packed {
    logic [3:0][7:0] sub_scale;
    logic [15:0]     scale;
    logic [15:0]     min_scale;
    logic [7:0]      codes;
    logic [7:0]      base;
  } entry_t;

endpackage

[sv/q2k_block_dequantizer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2k_block_dequantizer_unit: 2-bit super-block dequantizer
// Header words load the block scales; each quant byte yields four fp32 values.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | word
//  in      | input     | in_valid_i / in_stall_o   | command, header fields, byte
//  out     | output    | out_valid_o / out_stall_i | four fp32 values, base index
//
// One word is taken per cycle while the queue has room; a quant byte's result
// is valid once it has passed through the queue and then the lane stages.
// Header words produce no result and update the state in the cycle taken.
// Reset clears the block scales and scale bytes to zero and empties the pipe.
// A stalled output holds the pipeline; the input stalls once the queue fills.
// ----------------------------------------------------------------------------
module q2k_block_dequantizer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [15:0] block_scale_i,
  input  logic [15:0] block_min_scale_i,
  input  logic [63:0] scales_low_i,
  input  logic [63:0] scales_high_i,
  input  logic [7:0]  quant_byte_i,
  input  logic [5:0]  byte_position_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] value_zero_o,
  output logic [31:0] value_one_o,
  output logic [31:0] value_two_o,
  output logic [31:0] value_three_o,
  output logic [7:0]  base_index_o
);

  q2k_pkg::entry_t  push_entry;
  q2k_pkg::entry_t  pop_entry;
  logic             push, pop, q_full, q_empty;

  q2k_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .block_scale_i     (block_scale_i),
    .block_min_scale_i (block_min_scale_i),
    .scales_low_i      (scales_low_i),
    .scales_high_i     (scales_high_i),
    .quant_byte_i      (quant_byte_i),
    .byte_position_i   (byte_position_i),
    .q_full_i          (q_full),
    .push_o            (push),
    .entry_o           (push_entry)
  );

  q2k_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  q2k_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .entry_i       (pop_entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .value_zero_o  (value_zero_o),
    .value_one_o   (value_one_o),
    .value_two_o   (value_two_o),
    .value_three_o (value_three_o),
    .base_index_o  (base_index_o)
  );

  // The queue is never written while full.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !push) else $error("queue written while full");

  // The back never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_empty |-> !pop) else $error("pop from empty queue");

  // Every NaN on value_zero_o leaving the block is the canonical one.
  a_canon_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (value_zero_o[30:23] == 8'hFF) && (value_zero_o[22:0] != 23'd0))
    |-> (value_zero_o == q2k_pkg::CanonNan)) else $error("non-canonical NaN");

endmodule

[sv/q2k_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2k_front: input side of the dequantizer
// Takes header and quant words, keeps the block state and resolves the four
// scale bytes of each quant byte into a queue word.
// ----------------------------------------------------------------------------
module q2k_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 command_i,
  input  logic [15:0]          block_scale_i,
  input  logic [15:0]          block_min_scale_i,
  input  logic [63:0]          scales_low_i,
  input  logic [63:0]          scales_high_i,
  input  logic [7:0]           quant_byte_i,
  input  logic [5:0]           byte_position_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output q2k_pkg::entry_t      entry_o
);

  logic [15:0]          scale_q;
  logic [15:0]          min_scale_q;
  logic [15:0][7:0]     sub_q;
  logic                 accept;

  // A word is taken whenever the queue has room.
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = accept && (command_i == q2k_pkg::CMD_QUANT);

  // Header words load the block state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q     <= '0;
      min_scale_q <= '0;
      sub_q       <= '0;
    end else if (accept && (command_i == q2k_pkg::CMD_HEADER)) begin
      scale_q     <= block_scale_i;
      min_scale_q <= block_min_scale_i;
      sub_q       <= {scales_high_i, scales_low_i};
    end
  end

  // Scale byte of code k sits at {h, k, j >= 16}.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      entry_o.sub_scale[k] = sub_q[{byte_position_i[5], 2'(k), byte_position_i[4]}];
    end
    entry_o.scale     = scale_q;
    entry_o.min_scale = min_scale_q;
    entry_o.codes     = quant_byte_i;
    entry_o.base      = {byte_position_i[5], 2'b00, byte_position_i[4:0]};
  end

endmodule

[sv/q2k_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2k_queue: two-word queue between front and back
// Lets the front keep taking words while the back is stalled.
// ----------------------------------------------------------------------------
module q2k_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  q2k_pkg::entry_t      entry_i,
  input  logic                 pop_i,
  output q2k_pkg::entry_t      entry_o,
  output logic                 full_o,
  output logic                 empty_o
);

  q2k_pkg::entry_t  mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign entry_o = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

[sv/q2k_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2k_lane: one dequantized value
// Four stages: exact products, aligned subtraction, leading one search,
// then normalization, round to nearest even and packing to fp32.
// ----------------------------------------------------------------------------
module q2k_lane (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] scale_i,
  input  logic [15:0] min_scale_i,
  input  logic [7:0]  sub_scale_i,
  input  logic [1:0]  code_i,
  output logic [31:0] value_o
);

  localparam int MagW = q2k_pkg::MagW;

  // Stage one: decode the halves and form the exact integer products.
  logic [4:0]  d_exp, m_exp, d_e, m_e;
  logic [10:0] d_man, m_man;
  logic [14:0] d_prod, m_prod;
  logic [16:0] a_mag;
  logic        d_sp, m_sp, d_nan, m_nan;

  assign d_exp  = scale_i[14:10];
  assign m_exp  = min_scale_i[14:10];
  assign d_e    = (d_exp == 5'd0) ? 5'd1 : d_exp;
  assign m_e    = (m_exp == 5'd0) ? 5'd1 : m_exp;
  assign d_man  = {d_exp != 5'd0, scale_i[9:0]};
  assign m_man  = {m_exp != 5'd0, min_scale_i[9:0]};
  assign d_prod = {4'b0, d_man} * {11'b0, sub_scale_i[3:0]};
  assign m_prod = {4'b0, m_man} * {11'b0, sub_scale_i[7:4]};
  assign a_mag  = ({2'b0, d_prod} & {17{code_i[0]}})
                + ({1'b0, d_prod, 1'b0} & {17{code_i[1]}});
  assign d_sp   = (d_exp == 5'h1F);
  assign m_sp   = (m_exp == 5'h1F);
  assign d_nan  = d_sp && (scale_i[9:0] != 10'd0);
  assign m_nan  = m_sp && (min_scale_i[9:0] != 10'd0);

  logic [16:0] a1_q;
  logic [14:0] b1_q;
  logic [4:0]  ea1_q, eb1_q;
  logic        sa1_q, sb1_q, an1_q, ai1_q, bn1_q, bi1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q  <= a_mag;
      b1_q  <= m_prod;
      ea1_q <= d_e;
      eb1_q <= m_e;
      sa1_q <= scale_i[15];
      sb1_q <= min_scale_i[15];
      an1_q <= d_nan || (d_sp && (a_mag == 17'd0));
      ai1_q <= d_sp && !d_nan && (a_mag != 17'd0);
      bn1_q <= m_nan || (m_sp && (m_prod == 15'd0));
      bi1_q <= m_sp && !m_nan && (m_prod != 15'd0);
    end
  end

  // Stage two: align to the smaller exponent and subtract exactly.
  logic [MagW-1:0] xa, xb, mag;
  logic [4:0]      dd, emin;
  logic            sg, nan2, inf2, isg2;

  always_comb begin
    if (ea1_q >= eb1_q) begin
      dd   = ea1_q - eb1_q;
      xa   = {30'b0, a1_q} << dd;
      xb   = {32'b0, b1_q};
      emin = eb1_q;
    end else begin
      dd   = eb1_q - ea1_q;
      xa   = {30'b0, a1_q};
      xb   = {32'b0, b1_q} << dd;
      emin = ea1_q;
    end
    if (sa1_q != sb1_q) begin
      mag = xa + xb;
      sg  = sa1_q;
    end else if (xa >= xb) begin
      mag = xa - xb;
      sg  = sa1_q && (xa != xb);
    end else begin
      mag = xb - xa;
      sg  = ~sa1_q;
    end
    nan2 = an1_q || bn1_q || (ai1_q && bi1_q && (sa1_q == sb1_q));
    inf2 = !nan2 && (ai1_q || bi1_q);
    isg2 = ai1_q ? sa1_q : ~sb1_q;
  end

  logic [MagW-1:0] mag2_q;
  logic [4:0]      emin2_q;
  logic            sg2_q, nan2_q, inf2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag2_q  <= mag;
      emin2_q <= emin;
      sg2_q   <= inf2 ? isg2 : sg;
      nan2_q  <= nan2;
      inf2_q  <= inf2;
    end
  end

  // Stage three: find the leading one.
  logic [5:0] lead;

  always_comb begin
    lead = 6'd0;
    for (int i = 0; i < MagW; i++) begin
      if (mag2_q[i]) begin
        lead = 6'(i);
      end
    end
  end

  logic [MagW-1:0] mag3_q;
  logic [5:0]      lead3_q;
  logic [4:0]      emin3_q;
  logic            sg3_q, nan3_q, inf3_q, zero3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag3_q  <= mag2_q;
      lead3_q <= lead;
      emin3_q <= emin2_q;
      sg3_q   <= sg2_q;
      nan3_q  <= nan2_q;
      inf3_q  <= inf2_q;
      zero3_q <= (mag2_q == '0);
    end
  end

  // Stage four: normalize, round to nearest even and pack.
  logic [MagW-1:0] norm;
  logic [7:0]      exp_b;
  logic            guard, sticky, rnd;
  logic [30:0]     body;
  logic [31:0]     packed_val;

  always_comb begin
    norm   = mag3_q << (6'(MagW - 1) - lead3_q);
    exp_b  = {2'b0, lead3_q} + {3'b0, emin3_q} + q2k_pkg::ExpOffset;
    guard  = norm[MagW-25];
    sticky = |norm[MagW-26:0];
    rnd    = guard && (sticky || norm[MagW-24]);
    body   = {exp_b, norm[MagW-2:MagW-24]} + 31'(rnd);
    if (nan3_q) begin
      packed_val = q2k_pkg::CanonNan;
    end else if (inf3_q) begin
      packed_val = {sg3_q, 8'hFF, 23'd0};
    end else if (zero3_q) begin
      packed_val = {sg3_q, 31'd0};
    end else begin
      packed_val = {sg3_q, body};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_o <= packed_val;
    end
  end

endmodule

[sv/q2k_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2k_back: arithmetic side of the dequantizer
// Pops queue words into four parallel lanes and holds the result word.
// ----------------------------------------------------------------------------
module q2k_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  q2k_pkg::entry_t      entry_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [31:0]          value_zero_o,
  output logic [31:0]          value_one_o,
  output logic [31:0]          value_two_o,
  output logic [31:0]          value_three_o,
  output logic [7:0]           base_index_o
);

  logic              en;
  logic              v1_q, v2_q, v3_q, vo_q;
  logic [7:0]        b1_q, b2_q, b3_q, bo_q;
  logic [3:0][31:0]  lane_val;

  // The pipeline moves whenever the result register is free or taken.
  assign en    = !(vo_q && out_stall_i);
  assign pop_o = en && !q_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= pop_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  // Output index travels alongside the lanes.
  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_q <= entry_i.base;
      b2_q <= b1_q;
      b3_q <= b2_q;
      bo_q <= b3_q;
    end
  end

  // One lane per packed code.
  for (genvar k = 0; k < 4; k++) begin : g_lane
    q2k_lane u_lane (
      .clk_i       (clk_i),
      .en_i        (en),
      .scale_i     (entry_i.scale),
      .min_scale_i (entry_i.min_scale),
      .sub_scale_i (entry_i.sub_scale[k]),
      .code_i      (entry_i.codes[2*k+1:2*k]),
      .value_o     (lane_val[k])
    );
  end

  assign out_valid_o   = vo_q;
  assign value_zero_o  = lane_val[0];
  assign value_one_o   = lane_val[1];
  assign value_two_o   = lane_val[2];
  assign value_three_o = lane_val[3];
  assign base_index_o  = bo_q;

endmodule

[tb/tb_q2k_block_dequantizer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_q2k_block_dequantizer_unit: self-checking bench of the block dequantizer
// Header and quant words go through a driver with random gaps. A monitor works
// out the four fp32 values of each quant word with exact integer arithmetic
// and checks every output word, in order, against them.
// ----------------------------------------------------------------------------
module tb_q2k_block_dequantizer_unit;

  typedef struct {
    q2k_pkg::cmd_e cmd;
    logic [15:0]   scale;
    logic [15:0]   min_scale;
    logic [63:0]   lo;
    logic [63:0]   hi;
    logic [7:0]    qbyte;
    logic [5:0]    pos;
    bit            wait_drain;
  } word_t;

  typedef struct {
    logic [3:0][31:0] vals;
    logic [7:0]       base;
  } values_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        command_i = 1'b0;
  logic [15:0] block_scale_i = '0;
  logic [15:0] block_min_scale_i = '0;
  logic [63:0] scales_low_i = '0;
  logic [63:0] scales_high_i = '0;
  logic [7:0]  quant_byte_i = '0;
  logic [5:0]  byte_position_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] value_zero_o, value_one_o, value_two_o, value_three_o;
  logic [7:0]  base_index_o;

  word_t   pending_words[$];
  values_t expected_values[$];

  // Block state as the predictor sees it.
  logic [15:0] cur_scale = '0;
  logic [15:0] cur_min_scale = '0;
  logic [7:0]  cur_sub[16];

  int  errors = 0;
  int  words_taken = 0;
  int  cycles = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  quiet = 1'b0;
  bit  took = 1'b0;

  q2k_block_dequantizer_unit DUT (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Widen a half to an integer mantissa and a power-of-two exponent.
  function automatic void half_parts(input logic [15:0] h, output longint mag,
                                     output int ex);
    if (h[14:10] == 5'd0) begin
      mag = h[9:0];
      ex  = -24;
    end else begin
      mag = {1'b1, h[9:0]};
      ex  = int'(h[14:10]) - 25;
    end
  endfunction

  // One dequantized value: d*(sc&15)*q - dmin*(sc>>4), rounded to nearest even.
  function automatic logic [31:0] dequant_value(input logic [15:0] dh,
      input logic [15:0] mh, input logic [7:0] sc, input logic [1:0] q);
    bit          d_spec, m_spec, a_nan, b_nan, neg;
    int          ca, cb, ed, em, emin, msb, sh;
    longint      md, mm, va, vb, n;
    logic [63:0] u, rem, half, mant;
    d_spec = (dh[14:10] == 5'h1f);
    m_spec = (mh[14:10] == 5'h1f);
    ca = int'(sc[3:0]) * int'(q);
    cb = int'(sc[7:4]);
    a_nan = d_spec && (dh[9:0] != 0 || ca == 0);
    b_nan = m_spec && (mh[9:0] != 0 || cb == 0);
    if (a_nan || b_nan) return q2k_pkg::CanonNan;
    if (d_spec && m_spec) begin
      if (dh[15] == mh[15]) return q2k_pkg::CanonNan;
      return {dh[15], 8'hff, 23'd0};
    end
    if (d_spec) return {dh[15], 8'hff, 23'd0};
    if (m_spec) return {~mh[15], 8'hff, 23'd0};
    half_parts(dh, md, ed);
    half_parts(mh, mm, em);
    md = md * ca;
    mm = mm * cb;
    if (md == 0 && mm == 0) return {dh[15] & ~mh[15], 31'd0};
    emin = (ed < em) ? ed : em;
    va = md <<< (ed - emin);
    vb = mm <<< (em - emin);
    if (dh[15]) va = -va;
    if (mh[15]) vb = -vb;
    n = va - vb;
    if (n == 0) return 32'd0;
    neg = (n < 0);
    u = neg ? -n : n;
    msb = 0;
    for (int i = 0; i < 64; i++) if (u[i]) msb = i;
    if (msb <= 23) begin
      mant = u << (23 - msb);
    end else begin
      sh   = msb - 23;
      mant = u >> sh;
      rem  = u & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && mant[0])) mant = mant + 1;
      if (mant == 64'd1 << 24) begin
        mant = mant >> 1;
        msb  = msb + 1;
      end
    end
    return {neg, 8'(msb + emin + 127), mant[22:0]};
  endfunction

  // Apply one taken word to the predicted state and queue its values.
  task automatic take_word(input word_t w);
    values_t e;
    int      hb, jb;
    if (w.cmd == q2k_pkg::CMD_HEADER) begin
      cur_scale     = w.scale;
      cur_min_scale = w.min_scale;
      for (int i = 0; i < 8; i++) begin
        cur_sub[i]     = w.lo[8*i +: 8];
        cur_sub[8 + i] = w.hi[8*i +: 8];
      end
    end else begin
      hb = w.pos[5];
      jb = w.pos[4:0];
      for (int k = 0; k < 4; k++)
        e.vals[k] = dequant_value(cur_scale, cur_min_scale,
                                  cur_sub[hb*8 + 2*k + (jb >= 16 ? 1 : 0)],
                                  w.qbyte[2*k +: 2]);
      e.base = {w.pos[5], 2'b00, w.pos[4:0]};
      expected_values.push_back(e);
    end
  endtask

  // Half-precision pattern biased toward normal values, with specials now and then.
  function automatic logic [15:0] rand_half();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 65) return {1'($urandom), 5'($urandom_range(5, 20)), 10'($urandom)};
    if (sel < 75) return {1'($urandom), 5'd0, 10'($urandom)};
    if (sel < 80) return {1'($urandom), 15'd0};
    if (sel < 84) return {1'($urandom), 5'h1f, ($urandom_range(0, 1) ? 10'd0 : 10'($urandom))};
    return 16'($urandom);
  endfunction

  function automatic word_t make_word(input q2k_pkg::cmd_e c);
    word_t w;
    w.cmd        = c;
    w.scale      = rand_half();
    w.min_scale  = rand_half();
    w.lo         = {$urandom, $urandom};
    w.hi         = {$urandom, $urandom};
    w.qbyte      = 8'($urandom);
    w.pos        = 6'($urandom);
    w.wait_drain = 1'b0;
    return w;
  endfunction

  function automatic word_t make_header(input logic [15:0] s, input logic [15:0] m,
                                        input logic [63:0] lo, input logic [63:0] hi);
    word_t w;
    w = make_word(q2k_pkg::CMD_HEADER);
    w.scale = s;
    w.min_scale = m;
    w.lo = lo;
    w.hi = hi;
    return w;
  endfunction

  function automatic word_t make_quant(input logic [7:0] b, input logic [5:0] p);
    word_t w;
    w = make_word(q2k_pkg::CMD_QUANT);
    w.qbyte = b;
    w.pos = p;
    return w;
  endfunction

  // Fill the word queue, then wait for the last result.
  initial begin
    word_t w;
    int    nq;
    for (int i = 0; i < 16; i++) cur_sub[i] = '0;
    // Quant bytes before any header see the all-zero reset state.
    pending_words.push_back(make_quant(8'hff, 6'd0));
    pending_words.push_back(make_quant(8'h00, 6'd63));
    // Largest finite scales, all scale bytes at their maximum.
    pending_words.push_back(make_header(16'h7bff, 16'h7bff, '1, '1));
    pending_words.push_back(make_quant(8'hff, 6'd15));
    pending_words.push_back(make_quant(8'h1b, 6'd16));
    // Negative and subnormal scales, zero and mixed scale bytes.
    pending_words.push_back(make_header(16'h8001, 16'h03ff, 64'h0f1e2d3c4b5a6978,
                                        64'h8796a5b4c3d2e1f0));
    pending_words.push_back(make_quant(8'he4, 6'd31));
    pending_words.push_back(make_quant(8'h39, 6'd32));
    // Infinite scale against zero and nonzero factors.
    pending_words.push_back(make_header(16'h7c00, 16'hfc00, 64'h00f0_0f11_f0f0_1f2f,
                                        64'h0011_2233_4455_6677));
    pending_words.push_back(make_quant(8'hff, 6'd0));
    pending_words.push_back(make_quant(8'h00, 6'd48));
    // Equal infinities that cancel into a NaN, then a NaN scale.
    pending_words.push_back(make_header(16'h7c00, 16'h7c00, '1, '1));
    pending_words.push_back(make_quant(8'h55, 6'd47));
    pending_words.push_back(make_header(16'h7e01, 16'h3c00, '1, '1));
    pending_words.push_back(make_quant(8'hff, 6'd63));
    // Signed zeros and an exact cancellation.
    pending_words.push_back(make_header(16'h8000, 16'h8000, 64'h1111_1111_1111_1111,
                                        64'h1111_1111_1111_1111));
    pending_words.push_back(make_quant(8'h55, 6'd5));
    pending_words.push_back(make_header(16'h3c00, 16'h3c00, 64'h1111_1111_1111_1111,
                                        '0));
    pending_words.push_back(make_quant(8'h55, 6'd20));
    pending_words.push_back(make_quant(8'haa, 6'd40));
    // Random blocks: a header, then a run of quant bytes; a few stray headers.
    nq = 0;
    while (nq < 1230) begin
      w = make_word(q2k_pkg::CMD_HEADER);
      if (nq == 600) w.wait_drain = 1'b1;
      pending_words.push_back(w);
      nq++;
      for (int i = $urandom_range(4, 64); i > 0; i--) begin
        w = make_word($urandom_range(0, 19) == 0 ? q2k_pkg::CMD_HEADER : q2k_pkg::CMD_QUANT);
        if (nq == 600) w.wait_drain = 1'b1;
        pending_words.push_back(w);
        nq++;
      end
    end
    wait (rst_ni);
    wait (pending_words.size() == 0 && !in_valid_i && expected_values.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // Reset and a cycle limit.
  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 300000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Monitor: record taken input words and check each output word.
  always @(posedge clk_i) begin
    values_t e;
    word_t   w;
    bit      tk;
    tk = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        w.cmd = q2k_pkg::cmd_e'(command_i);
        w.scale = block_scale_i;
        w.min_scale = block_min_scale_i;
        w.lo = scales_low_i;
        w.hi = scales_high_i;
        w.qbyte = quant_byte_i;
        w.pos = byte_position_i;
        take_word(w);
        words_taken <= words_taken + 1;
        tk = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_values.size() == 0) begin
          $error("output word with nothing expected");
          errors++;
        end else begin
          e = expected_values.pop_front();
          if (value_zero_o !== e.vals[0]) begin
            $error("value_zero: expected %h, got %h", e.vals[0], value_zero_o);
            errors++;
          end
          if (value_one_o !== e.vals[1]) begin
            $error("value_one: expected %h, got %h", e.vals[1], value_one_o);
            errors++;
          end
          if (value_two_o !== e.vals[2]) begin
            $error("value_two: expected %h, got %h", e.vals[2], value_two_o);
            errors++;
          end
          if (value_three_o !== e.vals[3]) begin
            $error("value_three: expected %h, got %h", e.vals[3], value_three_o);
            errors++;
          end
          if (base_index_o !== e.base) begin
            $error("base_index: expected %h, got %h", e.base, base_index_o);
            errors++;
          end
        end
      end
    end
    took <= tk;
  end

  // Driver: offer the next word once the current one is taken.
  always @(negedge clk_i) begin
    word_t w;
    bit    nv;
    nv = in_valid_i;
    if (pending_words.size() < 200) quiet = 1'b1;
    if (rst_ni && (!in_valid_i || took)) begin
      nv = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_words.size() > 0 &&
                   (!pending_words[0].wait_drain || expected_values.size() == 0)) begin
        if (!quiet && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 13);
        end else begin
          w = pending_words.pop_front();
          command_i         <= w.cmd;
          block_scale_i     <= w.scale;
          block_min_scale_i <= w.min_scale;
          scales_low_i      <= w.lo;
          scales_high_i     <= w.hi;
          quant_byte_i      <= w.qbyte;
          byte_position_i   <= w.pos;
          nv = 1'b1;
        end
      end
    end
    in_valid_i <= nv;
  end

  // Receiver: random stall bursts and one long hold while words keep coming.
  always @(negedge clk_i) begin
    bit st;
    st = 1'b0;
    if (!hold_done && words_taken >= 300) begin
      hold_done = 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      st = 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      st = 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      recv_gap = $urandom_range(0, 13);
      st = 1'b1;
    end
    out_stall_i <= st;
  end

endmodule
